@@ sv/spq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants and controller/datapath interface types for the sorted
// priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH_DEF          = 16;
	localparam int DATA_WIDTH_DEF     = 32;
	localparam int PRIORITY_WIDTH_DEF = 16;

	// width of the reported count field
	localparam int COUNT_OUT_W = 5;
	localparam int STATUS_W    = 2;

	localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY_POP = 2'd2;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	localparam logic ORDER_LARGEST  = 1'b0;
	localparam logic ORDER_SMALLEST = 1'b1;

	typedef struct packed {
		logic                latch;   // capture request payload
		logic                push;    // insert captured entry
		logic                pop;     // remove head entry
		logic                load;    // load result register
		logic [STATUS_W-1:0] status;  // status code for the result
	} ctl_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dp_stat_t;

endpackage
`default_nettype wire

@@ sv/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// a request is captured when accepted in the idle state; its result is registered
//   in the execute state, which waits while the previous result still waits for m_tready
// no new request is taken until the controller's single execute state that
//   follows each accepted request has completed
// the next request is taken while a result still waits on the output side
// reset clears the entry count and sets order_mode to largest-first; entry
//   storage is not cleared, so the queue is usable right after reset
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Sorted-list priority queue with push/pop requests and a head/count result.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int DEPTH          = spq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH     = spq_pkg::DATA_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF,
	localparam int IN_W  = ((DATA_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((DATA_WIDTH + PRIORITY_WIDTH + spq_pkg::COUNT_OUT_W + 7) / 8) * 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic                         cfg_data,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [IN_W-1:0]              s_tdata,   // item_data, item_priority
	input  wire logic [0:0]                   s_tuser,   // req_type
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic      [OUT_W-1:0]             m_tdata,   // head_data, head_priority, entry_count
	output logic      [spq_pkg::STATUS_W-1:0] m_tuser    // status
);
	import spq_pkg::*;

	ctl_cmd_t                  cmd;
	dp_stat_t                  stat;
	logic [DATA_WIDTH-1:0]     res_data;
	logic [PRIORITY_WIDTH-1:0] res_prio;
	logic [COUNT_OUT_W-1:0]    res_count;

	assign cfg_ready = 1'b1;

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req_type (s_tuser[0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	spq_datapath #(
		.DEPTH          (DEPTH),
		.DATA_WIDTH     (DATA_WIDTH),
		.PRIORITY_WIDTH (PRIORITY_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (s_tdata[DATA_WIDTH-1:0]),
		.in_prio    (s_tdata[DATA_WIDTH +: PRIORITY_WIDTH]),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_mode   (cfg_data),
		.cmd        (cmd),
		.stat       (stat),
		.res_data   (res_data),
		.res_prio   (res_prio),
		.res_count  (res_count),
		.res_status (m_tuser)
	);

	assign m_tdata = OUT_W'({res_count, res_prio, res_data});

endmodule
`default_nettype wire

@@ sv/spq_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_datapath
// Row of sorted entry cells with per-cell compare, count, order mode and the
// result register.
// ----------------------------------------------------------------------------
module spq_datapath #(
	parameter int DEPTH          = spq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH     = spq_pkg::DATA_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [DATA_WIDTH-1:0]           in_data,
	input  wire logic [PRIORITY_WIDTH-1:0]       in_prio,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_mode,
	input  wire spq_pkg::ctl_cmd_t               cmd,
	output spq_pkg::dp_stat_t                    stat,
	output logic      [DATA_WIDTH-1:0]           res_data,
	output logic      [PRIORITY_WIDTH-1:0]       res_prio,
	output logic      [spq_pkg::COUNT_OUT_W-1:0] res_count,
	output logic      [spq_pkg::STATUS_W-1:0]    res_status
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0]     req_data_q;
	logic [PRIORITY_WIDTH-1:0] req_prio_q;
	logic                      order_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_nxt;

	logic [DATA_WIDTH-1:0]     data_q   [DEPTH];
	logic [PRIORITY_WIDTH-1:0] prio_q   [DEPTH];
	logic [DATA_WIDTH-1:0]     data_nxt [DEPTH];
	logic [PRIORITY_WIDTH-1:0] prio_nxt [DEPTH];
	logic [DEPTH-1:0]          behind;
	logic [DEPTH-1:0]          behind_run;

	logic [DATA_WIDTH-1:0]          res_data_q;
	logic [PRIORITY_WIDTH-1:0]      res_prio_q;
	logic [COUNT_OUT_W-1:0]         res_count_q;
	logic [STATUS_W-1:0]            res_status_q;
	logic [CNT_W+COUNT_OUT_W-1:0]   count_ext;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_data_q <= in_data;
			req_prio_q <= in_prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_LARGEST;
		end else if (cfg_we) begin
			order_q <= cfg_mode;
		end
	end

	// each cell decides whether the new entry goes behind its stored entry
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		always_comb begin
			behind[i] = (CNT_W'(i) < count_q) &&
				((order_q == ORDER_SMALLEST) ? (req_prio_q > prio_q[i])
				                             : (req_prio_q < prio_q[i]));
		end

		// new entry goes behind every cell from the head up to this one
		if (i == 0) begin : g_run_head
			assign behind_run[i] = behind[i];
		end else begin : g_run_rest
			assign behind_run[i] = behind_run[i-1] && behind[i];
		end

		always_comb begin
			data_nxt[i] = data_q[i];
			prio_nxt[i] = prio_q[i];
			if (cmd.push && !behind_run[i]) begin
				if (i == 0) begin
					data_nxt[i] = req_data_q;
					prio_nxt[i] = req_prio_q;
				end else if (behind_run[(i == 0) ? 0 : i-1]) begin
					data_nxt[i] = req_data_q;
					prio_nxt[i] = req_prio_q;
				end else begin
					data_nxt[i] = data_q[(i == 0) ? 0 : i-1];
					prio_nxt[i] = prio_q[(i == 0) ? 0 : i-1];
				end
			end else if (cmd.pop && (i < DEPTH-1)) begin
				data_nxt[i] = data_q[(i < DEPTH-1) ? i+1 : i];
				prio_nxt[i] = prio_q[(i < DEPTH-1) ? i+1 : i];
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.push || cmd.pop) begin
				data_q[i] <= data_nxt[i];
				prio_q[i] <= prio_nxt[i];
			end
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (cmd.push) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	assign count_ext = {{COUNT_OUT_W{1'b0}}, count_nxt};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_data_q   <= (count_nxt != '0) ? data_nxt[0] : '0;
			res_prio_q   <= (count_nxt != '0) ? prio_nxt[0] : '0;
			res_count_q  <= count_ext[COUNT_OUT_W-1:0];
			res_status_q <= cmd.status;
		end
	end

	assign stat.full   = (count_q == CNT_W'(DEPTH));
	assign stat.empty  = (count_q == '0);
	assign res_data    = res_data_q;
	assign res_prio    = res_prio_q;
	assign res_count   = res_count_q;
	assign res_status  = res_status_q;

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("count did not grow on push");
	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("count did not shrink on pop");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !stat.full)
		else $error("push into full queue");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !stat.empty && !cmd.push)
		else $error("pop on empty queue or together with push");

endmodule
`default_nettype wire

@@ sv/spq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl
// Request sequencer: accepts a request, executes it in the datapath when the
// result slot is free, and holds the result handshake.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic              req_type,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	input  wire spq_pkg::dp_stat_t stat,
	output spq_pkg::ctl_cmd_t      cmd
);
	import spq_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic req_pop_q;
	logic out_valid_q;
	logic exec;

	assign s_tready = (state_q == ST_IDLE);
	assign exec     = (state_q == ST_EXEC) && (!out_valid_q || m_tready);

	always_comb begin
		cmd.latch  = s_tvalid && s_tready;
		cmd.load   = exec;
		cmd.push   = exec && (req_pop_q == REQ_PUSH) && !stat.full;
		cmd.pop    = exec && (req_pop_q == REQ_POP) && !stat.empty;
		unique case (req_pop_q)
			REQ_PUSH: cmd.status = stat.full ? STATUS_FULL : STATUS_DONE;
			REQ_POP:  cmd.status = stat.empty ? STATUS_EMPTY_POP : STATUS_DONE;
			default:  cmd.status = STATUS_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_pop_q   <= REQ_PUSH;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q   <= ST_EXEC;
						req_pop_q <= req_type;
					end
				end
				ST_EXEC: begin
					if (exec) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !out_valid_q || m_tready)
		else $error("result overwritten before it was taken");
	a_exec_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_IDLE && out_valid_q)
		else $error("execute did not complete");
	a_no_latch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> state_q == ST_EXEC && !cmd.latch)
		else $error("request captured while busy");

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted priority queue: streams push and pop
// requests under random back-pressure, predicts head, count and status per
// request and compares every result in order; switches the head order between
// phases while the queue keeps its contents.
// ----------------------------------------------------------------------------
module tb;
	import spq_pkg::*;

	localparam int DEPTH  = DEPTH_DEF;
	localparam int DW     = DATA_WIDTH_DEF;
	localparam int PW     = PRIORITY_WIDTH_DEF;
	localparam int IN_W   = ((DW + PW + 7) / 8) * 8;
	localparam int OUT_W  = ((DW + PW + COUNT_OUT_W + 7) / 8) * 8;

	typedef struct {
		logic          req;
		logic [DW-1:0] data;
		logic [PW-1:0] prio;
		bit            wait_drain;
	} request_t;

	typedef struct {
		logic [DW-1:0]          head_data;
		logic [PW-1:0]          head_priority;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic [STATUS_W-1:0]    status;
	} result_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                cfg_data  = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata   = '0;   // item_data, item_priority
	logic [0:0]          s_tuser   = '0;   // req_type
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [OUT_W-1:0]    m_tdata;          // head_data, head_priority, entry_count
	logic [STATUS_W-1:0] m_tuser;          // status

	sorted_priority_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// shadow copy of the queue contents and head order
	logic [DW-1:0] queue_data [DEPTH];
	logic [PW-1:0] queue_prio [DEPTH];
	int            queue_count = 0;
	logic          order_sel   = ORDER_LARGEST;

	request_t pending_requests[$];
	result_t  expected_heads[$];
	request_t in_flight;
	result_t  want;
	int       requests_queued   = 0;
	int       requests_accepted = 0;
	int       error_count       = 0;
	int       send_idle_pct     = 38;
	int       recv_idle_pct     = 82;

	function automatic result_t apply_request(input request_t r);
		result_t res;
		int      pos;
		res.status = STATUS_DONE;
		if (r.req == REQ_PUSH) begin
			if (queue_count >= DEPTH) begin
				res.status = STATUS_FULL;
			end else begin
				pos = 0;
				// walk past every entry the new one strictly follows
				while (pos < queue_count &&
				       ((order_sel == ORDER_SMALLEST) ? (r.prio > queue_prio[pos])
				                                       : (r.prio < queue_prio[pos])))
					pos++;
				for (int i = queue_count; i > pos; i--) begin
					queue_data[i] = queue_data[i-1];
					queue_prio[i] = queue_prio[i-1];
				end
				queue_data[pos] = r.data;
				queue_prio[pos] = r.prio;
				queue_count++;
			end
		end else begin
			if (queue_count == 0) begin
				res.status = STATUS_EMPTY_POP;
			end else begin
				for (int i = 0; i + 1 < queue_count; i++) begin
					queue_data[i] = queue_data[i+1];
					queue_prio[i] = queue_prio[i+1];
				end
				queue_count--;
			end
		end
		res.head_data     = (queue_count > 0) ? queue_data[0] : '0;
		res.head_priority = (queue_count > 0) ? queue_prio[0] : '0;
		res.entry_count   = queue_count[COUNT_OUT_W-1:0];
		return res;
	endfunction

	task automatic add_request(input logic req, input logic [DW-1:0] data,
	                           input logic [PW-1:0] prio, input bit wait_drain);
		request_t r;
		r.req        = req;
		r.data       = data;
		r.prio       = prio;
		r.wait_drain = wait_drain;
		pending_requests.push_back(r);
		requests_queued++;
	endtask

	task automatic add_random(input int n);
		int push_pct;
		int pick;
		logic [PW-1:0] prio;
		push_pct = 50;
		for (int i = 0; i < n; i++) begin
			// epochs biased toward filling, draining or neither so both ends are hit
			if (i % 40 == 0) begin
				pick = $urandom_range(0, 2);
				push_pct = (pick == 0) ? 20 : (pick == 1) ? 50 : 80;
			end
			pick = $urandom_range(0, 9);
			if (pick < 4)
				prio = PW'($urandom_range(0, 7));
			else if (pick == 4)
				prio = $urandom_range(0, 1) ? '1 : '0;
			else
				prio = PW'($urandom);
			add_request(($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP,
			            DW'($urandom), prio, (i % 150) == 75);
		end
	endtask

	task automatic wait_quiet();
		while (requests_accepted != requests_queued || expected_heads.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_order(input logic mode);
		wait_quiet();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		order_sel = mode;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_heads.push_back(apply_request(in_flight));
				requests_accepted++;
			end
			if (s_tvalid && !s_tready) begin
				// hold the current request
			end else if (pending_requests.size() != 0 &&
			             $urandom_range(0, 99) >= send_idle_pct &&
			             !(pending_requests[0].wait_drain && expected_heads.size() != 0)) begin
				in_flight = pending_requests.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= IN_W'({in_flight.prio, in_flight.data});
				s_tuser  <= in_flight.req;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_heads.size() == 0) begin
					$error("unexpected result: tdata %h tuser %h", m_tdata, m_tuser);
					error_count++;
				end else begin
					want = expected_heads.pop_front();
					if (m_tdata[DW-1:0] !== want.head_data) begin
						$error("head_data: expected %h, got %h", want.head_data,
						       m_tdata[DW-1:0]);
						error_count++;
					end
					if (m_tdata[DW+PW-1:DW] !== want.head_priority) begin
						$error("head_priority: expected %h, got %h", want.head_priority,
						       m_tdata[DW+PW-1:DW]);
						error_count++;
					end
					if (m_tdata[DW+PW+COUNT_OUT_W-1:DW+PW] !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d", want.entry_count,
						       m_tdata[DW+PW+COUNT_OUT_W-1:DW+PW]);
						error_count++;
					end
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						error_count++;
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		#5ms;
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, extremes, ties, fill past full
		add_request(REQ_POP, '1, '1, 0);
		add_request(REQ_PUSH, '0, '0, 0);
		add_request(REQ_PUSH, '1, '1, 0);
		add_request(REQ_PUSH, 32'h0000_0a01, 16'd5, 0);
		add_request(REQ_PUSH, 32'h0000_0a02, 16'd5, 0);
		add_request(REQ_PUSH, 32'h0000_0a03, 16'd5, 0);
		for (int i = 0; i < 11; i++)
			add_request(REQ_PUSH, DW'($urandom), PW'($urandom), 0);
		add_request(REQ_PUSH, 32'hdead_beef, 16'h8000, 0);
		for (int i = 0; i < 4; i++)
			add_request(REQ_POP, DW'($urandom), PW'($urandom), 0);

		write_order(ORDER_SMALLEST);
		add_random(600);
		write_order(ORDER_LARGEST);
		wait_quiet();
		send_idle_pct = 82;
		recv_idle_pct = 38;
		add_random(600);
		write_order(ORDER_SMALLEST);
		wait_quiet();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random(300);
		write_order(ORDER_LARGEST);
		add_random(300);

		wait_quiet();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
sv/spq_pkg.sv
sv/spq_datapath.sv
sv/spq_ctrl.sv
sv/sorted_priority_queue.sv
tb/sv/tb.sv
